>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks are sampled on the rising clock edge.
// All checks are disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold on every edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When ante holds, cons must hold on the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// When ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/rrtd_pkg.sv
`timescale 1ns / 1ps
package rrtd_pkg;

  localparam int IDX_W  = 4;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 16;

  localparam logic [2:0] MODE_RUN   = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_START = 3'd2;
  localparam logic [2:0] MODE_STOP  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTADDED = 2'd2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RUN,
    OP_ADD,
    OP_START,
    OP_STOP,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   task_index;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  interval_ms;
    logic [TIME_W-1:0]  first_due_ms;
    logic               start_enabled;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/core/rrtd_front.sv
`timescale 1ns / 1ps
module rrtd_front import rrtd_pkg::*; (
  input  logic              start_i,
  input  logic [2:0]        mode_i,
  input  logic [IDX_W-1:0]  task_index_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] interval_ms_i,
  input  logic [TIME_W-1:0] first_due_ms_i,
  input  logic              start_enabled_i,
  input  q_status_t         q_status_i,
  output logic              busy_o,
  output logic              push_o,
  output cmd_t              cmd_o
);

  op_e op;

  // mode decode; unused codes become a no-op
  always_comb begin
    unique case (mode_i)
      MODE_RUN:   op = OP_RUN;
      MODE_ADD:   op = OP_ADD;
      MODE_START: op = OP_START;
      MODE_STOP:  op = OP_STOP;
      MODE_CLEAR: op = OP_CLEAR;
      MODE_READ:  op = OP_READ;
      default:    op = OP_NONE;
    endcase
  end

  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

  assign cmd_o = '{
    op:            op,
    task_index:    task_index_i,
    now_ms:        now_ms_i,
    interval_ms:   interval_ms_i,
    first_due_ms:  first_due_ms_i,
    start_enabled: start_enabled_i
  };

endmodule

>>> rtl/core/rrtd_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrtd_queue import rrtd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output cmd_t      head_o,
  output q_status_t status_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);

  `ASSERT_ALWAYS(a_no_pop_empty, clk_i, rst_ni, !(pop_i && cnt_q == '0))
  `ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, cnt_q == QCNT_W'(QDEPTH), !push_i)

endmodule

>>> rtl/core/rrtd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrtd_back import rrtd_pkg::*; #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_status_t         q_status_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              done_o,
  output logic              dispatched_o,
  output logic [IDX_W-1:0]  result_index_o,
  output logic [CNT_W-1:0]  counter_value_o,
  output logic [1:0]        status_o
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic done_q;

  // task tables, no reset: read data is used only for entries below count_q
  logic [TIME_W-1:0] period_mem [MAX_TASKS];
  logic [TIME_W-1:0] due_mem    [MAX_TASKS];
  logic              en_mem     [MAX_TASKS];
  logic [CNT_W-1:0]  cnt_mem    [MAX_TASKS];

  cmd_t              cmd_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_period_q;
  logic [TIME_W-1:0] rd_due_q;
  logic              rd_en_q;
  logic [CNT_W-1:0]  rd_cnt_q;

  logic              we_period, we_due, we_en, we_cnt;
  logic [TIME_W-1:0] wd_due;
  logic              wd_en;
  logic [CNT_W-1:0]  wd_cnt;

  logic              disp_d;
  logic [IDX_W-1:0]  ridx_d;
  logic [CNT_W-1:0]  cval_d;
  logic [1:0]        stat_d;
  logic              dispatched_q;
  logic [IDX_W-1:0]  ridx_q;
  logic [CNT_W-1:0]  cval_q;
  logic [1:0]        stat_q;

  logic run_in_range, idx_ok, tbl_full, is_due;

  assign pop_o = (state_q == ST_IDLE) && !q_status_i.empty;

  // read address picked from the queue head
  always_comb begin
    unique case (head_i.op)
      OP_RUN:  rd_addr = ptr_q[AW-1:0];
      OP_ADD:  rd_addr = count_q[AW-1:0];
      default: rd_addr = AW'(head_i.task_index);
    endcase
  end

  assign run_in_range = (ptr_q < count_q);
  assign idx_ok       = (32'(cmd_q.task_index) < 32'(count_q));
  assign tbl_full     = (count_q == CW'(MAX_TASKS));
  assign is_due       = rd_en_q && (cmd_q.now_ms >= rd_due_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    we_period = 1'b0;
    we_due    = 1'b0;
    we_en     = 1'b0;
    we_cnt    = 1'b0;
    wd_due    = cmd_q.first_due_ms;
    wd_en     = cmd_q.start_enabled;
    wd_cnt    = '0;
    disp_d    = 1'b0;
    ridx_d    = '0;
    cval_d    = '0;
    stat_d    = STAT_OK;

    if (state_q == ST_IDLE) begin
      if (!q_status_i.empty) begin
        state_d = ST_EXEC;
      end
    end else begin
      state_d = ST_IDLE;
      unique case (cmd_q.op)
        OP_RUN: begin
          if (run_in_range) begin
            if (is_due) begin
              we_due = 1'b1;
              wd_due = cmd_q.now_ms + rd_period_q;
              we_cnt = 1'b1;
              wd_cnt = rd_cnt_q + 1'b1;
              disp_d = 1'b1;
              ridx_d = IDX_W'(addr_q);
            end
            ptr_d = ptr_q + 1'b1;
          end else begin
            ptr_d = '0;
          end
        end
        OP_ADD: begin
          if (!tbl_full) begin
            we_period = 1'b1;
            we_due    = 1'b1;
            we_en     = 1'b1;
            we_cnt    = 1'b1;
            ridx_d    = IDX_W'(addr_q);
            count_d   = count_q + 1'b1;
          end else begin
            stat_d = STAT_FULL;
          end
        end
        OP_START, OP_STOP: begin
          if (idx_ok) begin
            we_en = 1'b1;
            wd_en = (cmd_q.op == OP_START);
          end else begin
            stat_d = STAT_NOTADDED;
          end
        end
        OP_CLEAR: begin
          if (idx_ok) begin
            we_cnt = 1'b1;
          end else begin
            stat_d = STAT_NOTADDED;
          end
        end
        OP_READ: begin
          if (idx_ok) begin
            cval_d = rd_cnt_q;
          end else begin
            stat_d = STAT_NOTADDED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  // command capture and registered table read
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q       <= head_i;
      addr_q      <= rd_addr;
      rd_period_q <= period_mem[rd_addr];
      rd_due_q    <= due_mem[rd_addr];
      rd_en_q     <= en_mem[rd_addr];
      rd_cnt_q    <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_period) begin
      period_mem[addr_q] <= cmd_q.interval_ms;
    end
    if (we_due) begin
      due_mem[addr_q] <= wd_due;
    end
    if (we_en) begin
      en_mem[addr_q] <= wd_en;
    end
    if (we_cnt) begin
      cnt_mem[addr_q] <= wd_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      dispatched_q <= disp_d;
      ridx_q       <= ridx_d;
      cval_q       <= cval_d;
      stat_q       <= stat_d;
    end
  end

  assign done_o          = done_q;
  assign dispatched_o    = dispatched_q;
  assign result_index_o  = ridx_q;
  assign counter_value_o = cval_q;
  assign status_o        = stat_q;

  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_q, !done_q)
  `ASSERT_ALWAYS(a_count_max, clk_i, rst_ni, count_q <= CW'(MAX_TASKS))
  `ASSERT_ALWAYS(a_ptr_le_count, clk_i, rst_ni, ptr_q <= count_q)

endmodule

>>> rtl/core/round_robin_interval_task_dispatcher.sv
`timescale 1ns / 1ps
// Result strobe done_o follows the start transfer through the queue write,
//   table read and execute/write-back when the back end is idle.
// The back end reads then writes one table entry per command and pops the
//   next only after that write-back; a 2-entry queue absorbs start bursts.
// Reset: async active low clears task count, run pointer, queue and strobe;
//   task tables stay undefined until an add writes the entry. The receiver cannot stall.
module round_robin_interval_task_dispatcher import rrtd_pkg::*; #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        mode_i,
  input  logic [IDX_W-1:0]  task_index_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] interval_ms_i,
  input  logic [TIME_W-1:0] first_due_ms_i,
  input  logic              start_enabled_i,
  output logic              done_o,
  output logic              dispatched_o,
  output logic [IDX_W-1:0]  result_index_o,
  output logic [CNT_W-1:0]  counter_value_o,
  output logic [1:0]        status_o
);

  // Front end: decodes the mode into an operation and pushes the command.
  // busy only reflects a full queue, so commands keep flowing while the
  // back end works on an earlier one.
  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      cmd_in;
  cmd_t      cmd_head;

  rrtd_front u_front (
    .start_i         (start),
    .mode_i          (mode_i),
    .task_index_i    (task_index_i),
    .now_ms_i        (now_ms_i),
    .interval_ms_i   (interval_ms_i),
    .first_due_ms_i  (first_due_ms_i),
    .start_enabled_i (start_enabled_i),
    .q_status_i      (q_status),
    .busy_o          (busy),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  // Command queue decoupling front and back end.
  rrtd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .head_o   (cmd_head),
    .status_o (q_status)
  );

  // Back end: owns the task tables, count and round-robin pointer.
  // Each command reads its entry into registers when popped and writes it back
  // in the execute state, so a following command always sees the updated entry.
  rrtd_back #(
    .MAX_TASKS (MAX_TASKS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .head_i          (cmd_head),
    .pop_o           (pop),
    .done_o          (done_o),
    .dispatched_o    (dispatched_o),
    .result_index_o  (result_index_o),
    .counter_value_o (counter_value_o),
    .status_o        (status_o)
  );

endmodule
